// ===== rtl/core/mcs_pkg.sv =====
`timescale 1ns / 1ps
// mcs_pkg: shared types and constants for the midpoint circle stepper
// used by mcs_front, mcs_queue, mcs_back, the checker and the testbench

package mcs_pkg;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_ADD,
    F_ROOT,
    F_PUSH
  } front_state_t;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic [2:0] LAST_PIX = 3'd7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam int D_INIT = 3;
  localparam int D_DIAG = 10;
  localparam int D_AXIS = 6;

endpackage

// ===== rtl/core/mcs_front.sv =====
`timescale 1ns / 1ps
// mcs_front: accepts start and step beats, holds the circle state,
// computes the rounded radius by a bit-pair square root; uses mcs_pkg

module mcs_front #(
  parameter int N = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic                 s_tuser,
  input  logic [N-1:0]         center_x,
  input  logic [N-1:0]         center_y,
  input  logic [N-1:0]         edge_x,
  input  logic [N-1:0]         edge_y,
  input  logic                 q_full,
  output logic                 push,
  output logic [4*N+3:0]       entry
);
  import mcs_pkg::*;

  localparam int SQ_W = 2 * (N + 1);
  localparam int DW   = N + 5;
  localparam int OW   = N + 2;

  front_state_t state, state_next;

  logic [N-1:0]          cx, cy;
  logic signed [OW-1:0]  xo, yo;
  logic signed [DW-1:0]  dec;
  logic                  started;
  logic signed [N:0]     dx, dy;
  logic [SQ_W-1:0]       sqx, sqy;
  logic [SQ_W-1:0]       rem, root, bitm;

  logic                  accept, start_in, step_in, step_ok;
  logic signed [N:0]     dx_in, dy_in;
  logic signed [SQ_W-1:0] prod_x, prod_y;
  logic signed [OW-1:0]  xo_inc, yo_dec;
  logic signed [DW-1:0]  xi_e, yd_e, d_diag, d_axis;
  logic                  d_pos;
  logic signed [OW-1:0]  yo_step;
  logic signed [DW-1:0]  dec_step;
  logic [SQ_W-1:0]       trial, rem_n, root_n;
  logic                  ge;
  logic [N:0]            r_round;
  logic signed [DW-1:0]  r_ext, dec_start;

  assign accept   = s_tvalid && s_tready;
  assign start_in = accept && (s_tuser == MODE_START);
  assign step_in  = accept && (s_tuser == MODE_STEP);
  assign step_ok  = started && !(yo < xo);

  assign dx_in = {center_x[N-1], center_x} - {edge_x[N-1], edge_x};
  assign dy_in = {center_y[N-1], center_y} - {edge_y[N-1], edge_y};
  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  // one midpoint step
  assign xo_inc = xo + OW'(1);
  assign yo_dec = yo - OW'(1);
  assign xi_e   = {{(DW-OW){xo_inc[OW-1]}}, xo_inc};
  assign yd_e   = {{(DW-OW){yo_dec[OW-1]}}, yo_dec};
  assign d_pos  = !dec[DW-1] && (|dec);
  assign d_diag = dec + ((xi_e - yd_e) <<< 2) + DW'(D_DIAG);
  assign d_axis = dec + (xi_e <<< 2) + DW'(D_AXIS);
  assign yo_step  = d_pos ? yo_dec : yo;
  assign dec_step = d_pos ? d_diag : d_axis;

  // square root iteration
  assign trial  = root + bitm;
  assign ge     = rem >= trial;
  assign rem_n  = ge ? rem - trial : rem;
  assign root_n = ge ? (root >> 1) + bitm : root >> 1;

  assign r_round   = root[N:0] + ((rem > root) ? (N+1)'(1) : (N+1)'(0));
  assign r_ext     = {{(DW-N-1){1'b0}}, r_round};
  assign dec_start = DW'(D_INIT) - (r_ext <<< 1);

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (start_in) state_next = F_MUL;
      F_MUL:  state_next = F_ADD;
      F_ADD:  state_next = F_ROOT;
      F_ROOT: if (bitm[0]) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    push     = 1'b0;
    entry    = {cx, cy, xo_inc, yo_step};
    unique case (state)
      F_IDLE: begin
        s_tready = !q_full;
        push     = step_in && step_ok;
      end
      F_PUSH: begin
        push  = !q_full;
        entry = {cx, cy, OW'(0), {1'b0, r_round}};
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      cx      <= '0;
      cy      <= '0;
      xo      <= '0;
      yo      <= '0;
      dec     <= '0;
      started <= 1'b0;
    end else begin
      state <= state_next;
      if (start_in) begin
        cx <= center_x;
        cy <= center_y;
      end
      if (state == F_IDLE && step_in && step_ok) begin
        xo  <= xo_inc;
        yo  <= yo_step;
        dec <= dec_step;
      end
      if (state == F_PUSH && !q_full) begin
        xo      <= '0;
        yo      <= {1'b0, r_round};
        dec     <= dec_start;
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_in) begin
      dx <= dx_in;
      dy <= dy_in;
    end
    if (state == F_MUL) begin
      sqx <= unsigned'(prod_x);
      sqy <= unsigned'(prod_y);
    end
    if (state == F_ADD) begin
      rem  <= sqx + sqy;
      root <= '0;
      bitm <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (state == F_ROOT) begin
      rem  <= rem_n;
      root <= root_n;
      bitm <= bitm >> 2;
    end
  end

endmodule

// ===== rtl/core/mcs_queue.sv =====
`timescale 1ns / 1ps
// mcs_queue: two-entry run queue between front and back
// depends on mcs_pkg for depth and pointer width

module mcs_queue #(
  parameter int W = 50
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] entry_in,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] entry_out
);
  import mcs_pkg::*;

  localparam int CNT_W = QPTR_W + 1;

  logic [W-1:0]      mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign valid     = count != '0;
  assign entry_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= entry_in;
  end

endmodule

// ===== rtl/core/mcs_back.sv =====
`timescale 1ns / 1ps
// mcs_back: expands one queued run into its eight symmetric pixels
// one beat per cycle unless the output stalls, through an output register; uses mcs_pkg

module mcs_back #(
  parameter int N = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  logic [4*N+3:0] q_entry,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [N+1:0]   pixel_x,
  output logic [N+1:0]   pixel_y,
  output logic           last_pixel
);
  import mcs_pkg::*;

  localparam int PW = N + 2;

  logic [4*N+3:0] cur;
  logic           cur_valid;
  logic [2:0]     idx;
  logic           load, run_done;

  logic [N-1:0]   ccx, ccy;
  logic [N+1:0]   cxo, cyo;
  logic [N+1:0]   a, b;
  logic [PW-1:0]  cx_e, cy_e, a_e, b_e, px, py;

  assign {ccx, ccy, cxo, cyo} = cur;

  assign load     = cur_valid && (!out_valid || out_ready);
  assign run_done = load && (idx == LAST_PIX);
  assign q_pop    = q_valid && (!cur_valid || run_done);

  assign a    = idx[2] ? cyo : cxo;
  assign b    = idx[2] ? cxo : cyo;
  assign cx_e = {{(PW-N){ccx[N-1]}}, ccx};
  assign cy_e = {{(PW-N){ccy[N-1]}}, ccy};
  assign a_e  = a;
  assign b_e  = b;
  assign px   = idx[0] ? cx_e - a_e : cx_e + a_e;
  assign py   = idx[1] ? cy_e - b_e : cy_e + b_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop)         cur_valid <= 1'b1;
      else if (run_done) cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_entry;
    if (load) begin
      pixel_x    <= px;
      pixel_y    <= py;
      last_pixel <= idx == LAST_PIX;
    end
  end

endmodule

// ===== rtl/core/midpoint_circle_stepper.sv =====
`timescale 1ns / 1ps
// midpoint_circle_stepper: top level of the midpoint circle stepper
// instantiates mcs_front, mcs_queue and mcs_back

// A start beat (tuser 0) latches the center and takes the radius as the rounded
// integer square root of the squared center-to-edge distance; a step beat
// (tuser 1) advances one octant point. Each run leaves as eight pixel beats,
// one per cycle unless stalled, tlast on the eighth. A step beat is pushed
// in the cycle it is accepted; a start beat holds the front through multiply,
// add, square root and push states, the square root unit resolving one result
// bit per cycle. Runs wait in a two-run queue; the single pixel output port sets
// the sustained rate. Steps before any start or past the octant give no beats.

module midpoint_circle_stepper #(
  parameter int COORD_BITS = 12,
  localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * (COORD_BITS + 2) + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // center_x, center_y, edge_x, edge_y, zero pad
  input  logic [IN_W-1:0]   s_tdata,
  // mode
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // pixel_x, pixel_y, zero pad
  output logic [OUT_W-1:0]  m_tdata,
  output logic              m_tlast
);
  localparam int N     = COORD_BITS;
  localparam int EW    = 4 * N + 4;

  logic          q_full, push, q_valid, q_pop;
  logic [EW-1:0] entry_in, entry_out;
  logic [N+1:0]  pixel_x, pixel_y;

  mcs_front #(.N(N)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .center_x (s_tdata[N-1:0]),
    .center_y (s_tdata[2*N-1:N]),
    .edge_x   (s_tdata[3*N-1:2*N]),
    .edge_y   (s_tdata[4*N-1:3*N]),
    .q_full   (q_full),
    .push     (push),
    .entry    (entry_in)
  );

  mcs_queue #(.W(EW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (entry_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .entry_out (entry_out)
  );

  mcs_back #(.N(N)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_entry    (entry_out),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (m_tlast)
  );

  assign m_tdata = OUT_W'({pixel_y, pixel_x});

endmodule

// ===== rtl/core/mcs_checker.sv =====
`timescale 1ns / 1ps
// mcs_checker: port-level assertions for midpoint_circle_stepper
// bound to the top level below; uses mcs_pkg

module mcs_checker #(
  parameter int COORD_BITS = 12,
  localparam int PW    = COORD_BITS + 2,
  localparam int OUT_W = ((2 * PW + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);
  import mcs_pkg::*;

  logic          beat;
  logic [2:0]    cnt;
  logic [PW-1:0] prev_y;

  assign beat = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (beat) begin
      cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) prev_y <= m_tdata[2*PW-1:PW];
  end

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled beat changed");

  a_last_every_eight: assert property (@(posedge clk) disable iff (rst)
    beat |-> (m_tlast == (cnt == LAST_PIX)))
    else $error("tlast not on eighth pixel of run");

  a_mirror_pair: assert property (@(posedge clk) disable iff (rst)
    beat && cnt[0] |-> m_tdata[2*PW-1:PW] == prev_y)
    else $error("mirrored pixel pair differs in y");

endmodule

bind midpoint_circle_stepper mcs_checker #(.COORD_BITS(COORD_BITS)) u_mcs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for midpoint_circle_stepper, with a circle predictor
// that checks every pixel beat; directed table first, then random circles; uses mcs_pkg

module testbench;
  import mcs_pkg::*;

  localparam int COORD_W = 12;
  localparam int PIX_W   = COORD_W + 2;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 32;
  localparam int RANDOM_ITEMS = 350;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic                    last;
  } pixel_t;

  typedef struct {
    logic   mode;
    coord_t cx;
    coord_t cy;
    coord_t ex;
    coord_t ey;
    logic   typed;
    int     typed_cnt;
    logic signed [PIX_W-1:0] tx;
    logic signed [PIX_W-1:0] ty;
  } row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  // circle state as the block should hold it
  coord_t             ctr_x = '0;
  coord_t             ctr_y = '0;
  logic signed [13:0] x_off = '0;
  logic signed [13:0] y_off = '0;
  logic signed [17:0] decision = '0;
  logic               started = 1'b0;

  pixel_t expected_pixels[$];
  row_t   directed[$];
  int     errors = 0;
  int     result_items = 0;
  int     send_idle = 13;
  int     recv_idle = 71;
  logic   hold_request = 1'b0;

  always #2 clk = ~clk;

  midpoint_circle_stepper #(.COORD_BITS(COORD_W)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  function automatic logic [25:0] rounded_root(input logic [25:0] n);
    logic [25:0] rem;
    logic [25:0] root;
    logic [25:0] b;
    rem = n;
    root = '0;
    b = 26'd1 << 24;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    if (rem > root) root = root + 26'd1;
    return root;
  endfunction

  task automatic circle_advance(input logic mode, input coord_t cx, input coord_t cy,
                                input coord_t ex, input coord_t ey,
                                output int count, output pixel_t run[8]);
    int dx;
    int dy;
    logic signed [13:0] a;
    logic signed [13:0] b;
    count = 0;
    if (mode == MODE_START) begin
      ctr_x = cx;
      ctr_y = cy;
      dx = int'(cx) - int'(ex);
      dy = int'(cy) - int'(ey);
      y_off = 14'(rounded_root(26'(dx * dx + dy * dy)));
      x_off = '0;
      decision = 18'(3 - 2 * int'(y_off));
      started = 1'b1;
      count = 8;
    end else if (started && y_off >= x_off) begin
      x_off = x_off + 14'sd1;
      if (decision > 0) begin
        y_off = y_off - 14'sd1;
        decision = 18'(decision + 4 * (x_off - y_off) + 10);
      end else begin
        decision = 18'(decision + 4 * x_off + 6);
      end
      count = 8;
    end
    for (int k = 0; k < 8; k++) begin
      a = (k < 4) ? x_off : y_off;
      b = (k < 4) ? y_off : x_off;
      run[k].x = (k % 2 == 1) ? ctr_x - a : ctr_x + a;
      run[k].y = ((k / 2) % 2 == 1) ? ctr_y - b : ctr_y + b;
      run[k].last = (k == 7);
    end
  endtask

  // one beat in, expectations queued on acceptance
  task automatic send_item(input logic mode, input coord_t cx, input coord_t cy,
                           input coord_t ex, input coord_t ey, input logic typed,
                           input int typed_cnt, input logic signed [PIX_W-1:0] tx,
                           input logic signed [PIX_W-1:0] ty);
    int     count;
    pixel_t run[8];
    pixel_t p;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {ey, ex, cy, cx};
    do @(posedge clk); while (!s_tready);
    circle_advance(mode, cx, cy, ex, ey, count, run);
    if (typed) begin
      for (int k = 0; k < typed_cnt; k++) begin
        p.x = tx;
        p.y = ty;
        p.last = (k == 7);
        expected_pixels.push_back(p);
      end
    end else begin
      for (int k = 0; k < count; k++) expected_pixels.push_back(run[k]);
    end
    if (count > 0) result_items++;
  endtask

  task automatic add_row(input logic mode, input int cx, input int cy, input int ex,
                         input int ey, input logic typed, input int typed_cnt,
                         input int tx, input int ty);
    row_t r;
    r.mode = mode;
    r.cx = coord_t'(cx);
    r.cy = coord_t'(cy);
    r.ex = coord_t'(ex);
    r.ey = coord_t'(ey);
    r.typed = typed;
    r.typed_cnt = typed_cnt;
    r.tx = PIX_W'(tx);
    r.ty = PIX_W'(ty);
    directed.push_back(r);
  endtask

  // receiver side: random stalls plus one long hold-off
  initial begin
    int   hold_left;
    logic hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.x = m_tdata[PIX_W-1:0];
      got.y = m_tdata[2*PIX_W-1:PIX_W];
      got.last = m_tlast;
      if (expected_pixels.size() == 0) begin
        errors++;
        $error("pixel beat with nothing expected: x %0d y %0d", got.x, got.y);
      end else begin
        want = expected_pixels.pop_front();
        if (got.x !== want.x) begin
          errors++;
          $error("pixel_x: expected %0d, got %0d", want.x, got.x);
        end
        if (got.y !== want.y) begin
          errors++;
          $error("pixel_y: expected %0d, got %0d", want.y, got.y);
        end
        if (got.last !== want.last) begin
          errors++;
          $error("last_pixel: expected %0b, got %0b", want.last, got.last);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    coord_t cx;
    coord_t cy;
    coord_t ex;
    coord_t ey;
    int     off_x;
    int     off_y;
    int     tmp;
    int     cap;
    int     n;
    int     phase;
    logic   hold_done;
    hold_done = 1'b0;

    // step before any start, zero radius, octant end, extremes, rounding
    add_row(MODE_STEP, 0, 0, 0, 0, 1'b1, 0, 0, 0);
    add_row(MODE_START, 0, 0, 0, 0, 1'b1, 8, 0, 0);
    add_row(MODE_STEP, 0, 0, 0, 0, 1'b0, 0, 0, 0);
    add_row(MODE_STEP, -1, -1, -1, -1, 1'b1, 0, 0, 0);
    add_row(MODE_START, 2047, 2047, -2048, -2048, 1'b0, 0, 0, 0);
    add_row(MODE_STEP, 0, 0, 0, 0, 1'b0, 0, 0, 0);
    add_row(MODE_STEP, 0, 0, 0, 0, 1'b0, 0, 0, 0);
    add_row(MODE_START, -2048, -2048, 2047, 2047, 1'b0, 0, 0, 0);
    add_row(MODE_STEP, 0, 0, 0, 0, 1'b0, 0, 0, 0);
    add_row(MODE_START, -2048, 2047, 2047, -2048, 1'b0, 0, 0, 0);
    add_row(MODE_START, -2048, 2047, -2048, 2047, 1'b1, 8, -2048, 2047);
    add_row(MODE_START, 0, 0, 1, 1, 1'b0, 0, 0, 0);
    add_row(MODE_START, 0, 0, 2, 2, 1'b0, 0, 0, 0);
    add_row(MODE_START, 0, 0, 2, 1, 1'b0, 0, 0, 0);
    add_row(MODE_START, 100, -50, 103, -46, 1'b0, 0, 0, 0);
    for (int k = 0; k < 6; k++) add_row(MODE_STEP, 0, 0, 0, 0, 1'b0, 0, 0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_item(directed[i].mode, directed[i].cx, directed[i].cy, directed[i].ex,
                directed[i].ey, directed[i].typed, directed[i].typed_cnt,
                directed[i].tx, directed[i].ty);

    result_items = 0;
    while (result_items < RANDOM_ITEMS) begin
      phase = result_items * 3 / RANDOM_ITEMS;
      send_idle = (phase == 0) ? 13 : (phase == 1) ? 71 : 0;
      recv_idle = (phase == 0) ? 71 : (phase == 1) ? 13 : 0;
      if (phase == 2 && !hold_done) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      cx = coord_t'($urandom);
      cy = coord_t'($urandom);
      if ($urandom_range(11) == 0) begin
        // far edge point: big radius, cut short
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
        cap = $urandom_range(6, 2);
      end else begin
        off_x = $urandom_range(40) - 20;
        off_y = $urandom_range(40) - 20;
        tmp = int'(cx) + off_x;
        ex = (tmp > 2047 || tmp < -2048) ? coord_t'(int'(cx) - off_x) : coord_t'(tmp);
        tmp = int'(cy) + off_y;
        ey = (tmp > 2047 || tmp < -2048) ? coord_t'(int'(cy) - off_y) : coord_t'(tmp);
        cap = ($urandom_range(7) == 0) ? $urandom_range(4) : 1000;
      end
      send_item(MODE_START, cx, cy, ex, ey, 1'b0, 0, 0, 0);
      n = 0;
      while (y_off >= x_off && n < cap) begin
        send_item(MODE_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), 1'b0, 0, 0, 0);
        n++;
      end
      if ($urandom_range(2) == 0)
        send_item(MODE_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), 1'b0, 0, 0, 0);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mcs_pkg.sv
rtl/core/mcs_front.sv
rtl/core/mcs_queue.sv
rtl/core/mcs_back.sv
rtl/core/midpoint_circle_stepper.sv
rtl/core/mcs_checker.sv
bench/testbench.sv
